// ===== rtl/core/mcr_pkg.sv =====
// mcr_pkg: shared types for the midpoint circle rasterizer
// controller state encoding and the command/status bundles between
// the controller and the datapath; no dependencies
`timescale 1ns / 1ps

package mcr_pkg;

   // controller states, one-hot
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_SQ_A = 7'b0000010,
      ST_SQ_B = 7'b0000100,
      ST_ROOT = 7'b0001000,
      ST_INIT = 7'b0010000,
      ST_STEP = 7'b0100000,
      ST_EMIT = 7'b1000000
   } mcr_state_type;

   // index of one point within a group of eight
   localparam int PT_IDX_W = 3;
   localparam logic [PT_IDX_W-1:0] PT_IDX_LAST = 3'd7;

   // request kinds carried on the input tuser
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic                capture;   // latch center and deltas of the endpoints
      logic                square_a;  // dx squared
      logic                square_b;  // add dy squared, arm the root unit
      logic                root_step; // one root bit
      logic                init;      // radius, offsets, decision
      logic                step;      // one midpoint iteration
      logic                emit;      // present point idx
      logic [PT_IDX_W-1:0] idx;
   } mcr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic root_last;  // final root iteration in progress
      logic r_zero;     // radius came out zero
      logic can_step;   // circle active and x < y
   } mcr_status_type;

endpackage

// ===== rtl/core/mcr_ctrl.sv =====
// mcr_ctrl: sequencing state machine of the rasterizer
// drives mcr_cmd_type commands, reads mcr_status_type; uses mcr_pkg
`timescale 1ns / 1ps

module mcr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_mode,
   output logic                    req_ready,
   input  logic                    out_free,
   input  mcr_pkg::mcr_status_type status,
   output mcr_pkg::mcr_cmd_type    cmd
);

   mcr_pkg::mcr_state_type        state_ff, state_in;
   logic [mcr_pkg::PT_IDX_W-1:0]  idx_ff, idx_in;
   logic                          accept;

   assign req_ready = (state_ff == mcr_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cmd           = '0;
      cmd.idx       = idx_ff;
      unique case (state_ff)
         mcr_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_mode == mcr_pkg::MODE_START) begin
                  cmd.capture = 1'b1;
                  state_in    = mcr_pkg::ST_SQ_A;
               end else begin
                  state_in    = mcr_pkg::ST_STEP;
               end
            end
         end
         mcr_pkg::ST_SQ_A: begin
            cmd.square_a = 1'b1;
            state_in     = mcr_pkg::ST_SQ_B;
         end
         mcr_pkg::ST_SQ_B: begin
            cmd.square_b = 1'b1;
            state_in     = mcr_pkg::ST_ROOT;
         end
         mcr_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_last) begin
               state_in = mcr_pkg::ST_INIT;
            end
         end
         mcr_pkg::ST_INIT: begin
            cmd.init = 1'b1;
            idx_in   = '0;
            state_in = status.r_zero ? mcr_pkg::ST_IDLE : mcr_pkg::ST_EMIT;
         end
         mcr_pkg::ST_STEP: begin
            cmd.step = 1'b1;
            idx_in   = '0;
            state_in = status.can_step ? mcr_pkg::ST_EMIT : mcr_pkg::ST_IDLE;
         end
         mcr_pkg::ST_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               idx_in   = idx_ff + 1'b1;
               if (idx_ff == mcr_pkg::PT_IDX_LAST) begin
                  state_in = mcr_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = mcr_pkg::ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcr_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== rtl/core/mcr_datapath.sv =====
// mcr_datapath: endpoint capture, squaring, bit-serial square root,
// midpoint iteration state and point generation; uses mcr_pkg
`timescale 1ns / 1ps

module mcr_datapath #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [COORD_BITS-1:0]        end_a_x,
   input  logic [COORD_BITS-1:0]        end_a_y,
   input  logic [COORD_BITS-1:0]        end_b_x,
   input  logic [COORD_BITS-1:0]        end_b_y,
   input  mcr_pkg::mcr_cmd_type         cmd,
   output mcr_pkg::mcr_status_type      status,
   output logic signed [COORD_BITS+1:0] point_x,
   output logic signed [COORD_BITS+1:0] point_y,
   output logic                         circle_done
);

   localparam int CB     = COORD_BITS;
   localparam int CEN_W  = CB + 1;
   localparam int DEC_W  = CB + 3;
   localparam int OUT_W  = CB + 2;
   localparam int PROD_W = 2 * CB;
   localparam int RAD_W  = 2 * CB + 2;
   localparam int ROOT_W = CB + 1;
   localparam int REM_W  = CB + 4;
   localparam int CNT_W  = $clog2(CB + 1);

   // circle state
   logic [CEN_W-1:0]  center_x_ff, center_y_ff;
   logic [CB-1:0]     offset_x_ff, offset_x_in;
   logic [CB-1:0]     offset_y_ff, offset_y_in;
   logic [DEC_W-1:0]  decision_ff, decision_in;
   logic              active_ff, active_in;
   logic              done_ff, done_in;

   // start arithmetic
   logic [CB-1:0]     dx_ff, dy_ff;
   logic [PROD_W-1:0] sq_a_ff;
   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;

   logic [CB:0]       sum_x, sum_y;
   logic [CB-1:0]     mul_op;
   logic [PROD_W-1:0] prod;
   logic [REM_W-1:0]  rem_sh, trial;
   logic              fits;
   logic [ROOT_W:0]   r_sum;
   logic [ROOT_W-1:0] radius;
   logic [DEC_W-1:0]  x2, y2;
   logic [CB-1:0]     x_nx, y_nx;

   // shared multiplier: dx first, then dy
   assign mul_op = cmd.square_b ? dy_ff : dx_ff;
   assign prod   = mul_op * mul_op;

   // one root bit per cycle: bring in two radicand bits, try 4q+1
   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = REM_W'({root_ff, 2'b01});
   assign fits   = (rem_sh >= trial);

   assign sum_x  = {1'b0, end_a_x} + {1'b0, end_b_x};
   assign sum_y  = {1'b0, end_a_y} + {1'b0, end_b_y};

   // radius from the root, rounded half up
   assign r_sum  = {1'b0, root_ff} + (ROOT_W+1)'(1);
   assign radius = r_sum[ROOT_W:1];

   assign x2 = {2'b00, offset_x_ff, 1'b0};
   assign y2 = {2'b00, offset_y_ff, 1'b0};

   assign status.root_last = (cnt_ff == '0);
   assign status.r_zero    = (root_ff == '0);
   assign status.can_step  = active_ff && (offset_x_ff < offset_y_ff);

   // endpoint capture and start pipeline
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         dx_ff       <= (end_a_x > end_b_x) ? end_a_x - end_b_x : end_b_x - end_a_x;
         dy_ff       <= (end_a_y > end_b_y) ? end_a_y - end_b_y : end_b_y - end_a_y;
      end
      if (cmd.square_a) begin
         sq_a_ff <= prod;
      end
      if (cmd.square_b) begin
         rad_ff  <= RAD_W'({1'b0, sq_a_ff} + {1'b0, prod});
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= CNT_W'(CB);
      end else if (cmd.root_step) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= fits ? rem_sh - trial : rem_sh;
         root_ff <= {root_ff[ROOT_W-2:0], fits};
         cnt_ff  <= cnt_ff - 1'b1;
      end
   end

   // circle center, taken on every start
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
      end else if (cmd.capture) begin
         center_x_ff <= {1'b0, sum_x[CB:1]};
         center_y_ff <= {1'b0, sum_y[CB:1]};
      end
   end

   // midpoint iteration and circle setup
   always_comb begin
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      decision_in = decision_ff;
      active_in   = active_ff;
      done_in     = done_ff;
      x_nx        = offset_x_ff + CB'(1);
      y_nx        = decision_ff[DEC_W-1] ? offset_y_ff : offset_y_ff - CB'(1);
      priority if (cmd.init) begin
         offset_x_in = '0;
         done_in     = 1'b0;
         if (status.r_zero) begin
            offset_y_in = '0;
            decision_in = '0;
            active_in   = 1'b0;
         end else begin
            offset_y_in = radius[CB-1:0];
            decision_in = DEC_W'(1) - DEC_W'(radius);
            active_in   = 1'b1;
         end
      end else if (cmd.step) begin
         if (status.can_step) begin
            if (decision_ff[DEC_W-1]) begin
               decision_in = decision_ff + x2 + DEC_W'(3);
            end else begin
               decision_in = decision_ff + x2 - y2 + DEC_W'(5);
            end
            offset_x_in = x_nx;
            offset_y_in = y_nx;
            active_in   = (x_nx < y_nx);
            done_in     = !(x_nx < y_nx);
         end else begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         decision_ff <= '0;
         active_ff   <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         offset_x_ff <= offset_x_in;
         offset_y_ff <= offset_y_in;
         decision_ff <= decision_in;
         active_ff   <= active_in;
         done_ff     <= done_in;
      end
   end

   // point of the group: bit 2 swaps axes, bit 0 negates h, bit 1 negates v
   logic [OUT_W-1:0] cx_e, cy_e, h_e, v_e;

   assign cx_e = OUT_W'(center_x_ff);
   assign cy_e = OUT_W'(center_y_ff);
   assign h_e  = OUT_W'(cmd.idx[2] ? offset_y_ff : offset_x_ff);
   assign v_e  = OUT_W'(cmd.idx[2] ? offset_x_ff : offset_y_ff);

   assign point_x     = cmd.idx[0] ? cx_e - h_e : cx_e + h_e;
   assign point_y     = cmd.idx[1] ? cy_e - v_e : cy_e + v_e;
   assign circle_done = done_ff;

endmodule

// ===== rtl/core/midpoint_circle_rasterizer_core.sv =====
// a start squares the endpoint distance, takes its root bit by bit and
// sets up the circle, a step runs one midpoint iteration; either then
// gives one point per cycle while the sink takes them, eight per group
// (none for a zero radius or a circle that cannot step); the controller
// is back in idle as the eighth point is registered; synchronous reset
// (active high) clears control and circle state, the output register comes up empty
`timescale 1ns / 1ps

module midpoint_circle_rasterizer_core #(
   parameter int COORD_BITS = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // end_a_x, end_a_y, end_b_x, end_b_y, zero pad
   input  logic [((4*COORD_BITS+7)/8)*8-1:0] req_tdata,
   // mode
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // point_x, point_y, zero pad
   output logic [((2*(COORD_BITS+2)+7)/8)*8-1:0] rsp_tdata,
   // last_point
   output logic rsp_tlast,
   // circle_done
   output logic rsp_tuser
);

   localparam int CB    = COORD_BITS;
   localparam int OUT_W = CB + 2;
   localparam int RSP_W = ((2*OUT_W+7)/8)*8;

   mcr_pkg::mcr_cmd_type    cmd;
   mcr_pkg::mcr_status_type status;

   logic signed [OUT_W-1:0] point_x, point_y;
   logic                    circle_done;
   logic                    out_free;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]        px_ff, py_ff;
   logic                    last_ff, done_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   mcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_mode  (req_tuser),
      .req_ready (req_tready),
      .out_free  (out_free),
      .status    (status),
      .cmd       (cmd)
   );

   mcr_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .end_a_x     (req_tdata[CB-1:0]),
      .end_a_y     (req_tdata[2*CB-1:CB]),
      .end_b_x     (req_tdata[3*CB-1:2*CB]),
      .end_b_y     (req_tdata[4*CB-1:3*CB]),
      .cmd         (cmd),
      .status      (status),
      .point_x     (point_x),
      .point_y     (point_y),
      .circle_done (circle_done)
   );

   // output word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         px_ff   <= point_x;
         py_ff   <= point_y;
         last_ff <= (cmd.idx == mcr_pkg::PT_IDX_LAST);
         done_ff <= circle_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({py_ff, px_ff});
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

endmodule

// ===== rtl/core/mcr_checker.sv =====
// mcr_checker: port-level assertions for the rasterizer core
// bound to midpoint_circle_rasterizer_core; no package use
`timescale 1ns / 1ps

module mcr_checker #(
   parameter int COORD_BITS = 12
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((2*(COORD_BITS+2)+7)/8)*8-1:0] rsp_tdata,
   input logic rsp_tlast,
   input logic rsp_tuser
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // one word at a time: busy right after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one still in work");

   // reset leaves an empty output and an idle input side
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

endmodule

bind midpoint_circle_rasterizer_core mcr_checker #(
   .COORD_BITS (COORD_BITS)
) u_mcr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
